[sv/dps_pkg.sv]
// Package for the drum pattern sequencer: sizes, field widths, register
// indexes, state and byte codes shared by the interfaces and the modules.
// Depends on nothing.
package dps_pkg;

    // Pattern geometry
    localparam int TRACK_COUNT     = 4;
    localparam int STEPS_PER_TRACK = 16;

    // Derived sizes
    localparam int TRK_W      = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int POS_W      = $clog2(STEPS_PER_TRACK + 1);
    localparam int STEP_IDX_W = $clog2(STEPS_PER_TRACK);
    localparam int STORE_DEPTH = TRACK_COUNT * STEPS_PER_TRACK;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);

    // Fixed field widths
    localparam int TRACK_W = 2;
    localparam int SLOT_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int TIME_W  = 12;
    localparam int CHAN_W  = 4;
    localparam int VEL_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = NOTE_W + TIME_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TIME_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_PERIOD   = 2'd0,
        REG_MIDI_CHANNEL  = 2'd1,
        REG_NOTE_VELOCITY = 2'd2
    } cfg_reg_e;

    // Register reset values
    localparam logic [TIME_W-1:0] PERIOD_RESET   = 12'd4000;
    localparam logic [CHAN_W-1:0] CHANNEL_RESET  = 4'd9;
    localparam logic [VEL_W-1:0]  VELOCITY_RESET = 7'd60;

    // MIDI note-on status with the channel nibble clear
    localparam logic [BYTE_W-1:0] NOTE_ON_STATUS = 8'h90;

    // Request kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // Position within one note-on message
    typedef enum logic [1:0] {
        BYTE_STATUS,
        BYTE_NOTE,
        BYTE_VELOCITY
    } byte_sel_t;

endpackage

[sv/dps_if.sv]
// Channel interfaces of the drum pattern sequencer: the request channel and
// the MIDI byte channel, each with valid/ready handshake.
// Depends on dps_pkg.
interface dps_cmd_if import dps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TRACK_W-1:0] track;
    logic [SLOT_W-1:0] slot;
    logic [NOTE_W-1:0] drum_note;
    logic [TIME_W-1:0] trigger_time;

    modport source (output valid, kind, track, slot, drum_note, trigger_time,
                    input ready);
    modport sink   (input valid, kind, track, slot, drum_note, trigger_time,
                    output ready);
endinterface

interface dps_midi_if import dps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] midi_byte;
    logic              last;

    modport source (output valid, midi_byte, last, input ready);
    modport sink   (input valid, midi_byte, last, output ready);
endinterface

[sv/dps_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module dps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/drum_pattern_sequencer_top.sv]
// Top level of the drum pattern sequencer: pattern store, loop counter,
// track pointers, scan sequencer and MIDI byte output register.
// Depends on dps_pkg, dps_if and dps_ram.

// A write request loads one step of the pattern store from the idle state.
// A tick request advances the loop counter, or wraps it and rewinds every
// track pointer, then scans the tracks in order through the READ and CHECK
// states, on the single read port of the pattern store, and finally sends
// the note-on bytes of the tracks that fired, one byte whenever the output
// register is free. The request channel is not ready until the sequencer is
// back in the idle state. The store reads as empty after reset through one
// valid flag per step, so no clearing pass is needed. The final byte of a
// tick carries last; a tick that fires nothing sends no bytes.
module drum_pattern_sequencer_top import dps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dps_cmd_if.sink               cmd,
    dps_midi_if.source            midi
);

    // Configuration registers
    logic [TIME_W-1:0] loop_period_reg;
    logic [CHAN_W-1:0] midi_channel_reg;
    logic [VEL_W-1:0]  note_velocity_reg;

    // Sequencer and loop state
    state_t            state_reg, state_next;
    logic [TIME_W-1:0] counter_reg, counter_next;
    logic [POS_W-1:0]  pos_reg [TRACK_COUNT];
    logic [POS_W-1:0]  pos_next [TRACK_COUNT];
    logic [TRK_W-1:0]  trk_reg, trk_next;
    logic [TRACK_COUNT-1:0] fire_mask_reg, fire_mask_next;
    logic [NOTE_W-1:0] note_reg [TRACK_COUNT];
    logic [NOTE_W-1:0] note_next [TRACK_COUNT];
    byte_sel_t         byte_sel_reg, byte_sel_next;
    logic              in_range_reg, in_range_next;
    logic              hit_valid_reg, hit_valid_next;

    // Store valid flags, one per step
    logic              entry_valid_reg [STORE_DEPTH];

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    // Store ports
    logic              store_we;
    logic [ADDR_W-1:0] store_waddr;
    logic [ADDR_W-1:0] store_raddr;
    logic [ENTRY_W-1:0] store_rdata;

    // Decoded control
    logic              tick_acc;
    logic              write_acc;
    logic              last_trk;
    logic              slot_free;
    logic              later_fired;
    logic              track_done;
    logic              load_out;
    logic [NOTE_W-1:0] step_drum;
    logic [TIME_W-1:0] step_time;
    logic              step_fire;

    dps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata ({cmd.drum_note, cmd.trigger_time}),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Handshake and request decode
    assign cmd.ready = (state_reg == ST_IDLE);
    assign tick_acc  = cmd.valid && (state_reg == ST_IDLE) && (cmd.kind == KIND_TICK);
    assign write_acc = cmd.valid && (state_reg == ST_IDLE) && (cmd.kind == KIND_WRITE);

    // Store write: out-of-range track or slot is dropped
    assign store_we    = write_acc && (int'(cmd.track) < TRACK_COUNT)
                                   && (int'(cmd.slot) < STEPS_PER_TRACK);
    assign store_waddr = ADDR_W'(int'(cmd.track) * STEPS_PER_TRACK + int'(cmd.slot));

    // Store read at the current step of the track under scan
    assign store_raddr = ADDR_W'(int'(trk_reg) * STEPS_PER_TRACK
                                 + int'(pos_reg[trk_reg][STEP_IDX_W-1:0]));

    // Step decode and the shared time compare
    assign step_drum = hit_valid_reg ? store_rdata[ENTRY_W-1:TIME_W] : '0;
    assign step_time = hit_valid_reg ? store_rdata[TIME_W-1:0] : '0;
    assign step_fire = in_range_reg && (step_drum != '0) && (counter_reg >= step_time);

    assign last_trk  = (trk_reg == TRK_W'(TRACK_COUNT - 1));
    assign slot_free = !out_valid_reg || midi.ready;

    // Whether a track after the current one fired in this tick
    always_comb
    begin
        later_fired = 1'b0;
        for (int i = 0; i < TRACK_COUNT; i++)
        begin
            if ((i > int'(trk_reg)) && fire_mask_reg[i])
            begin
                later_fired = 1'b1;
            end
        end
    end

    // Emission progress for the current track
    assign load_out   = (state_reg == ST_EMIT) && fire_mask_reg[trk_reg] && slot_free;
    assign track_done = !fire_mask_reg[trk_reg]
                        || (slot_free && (byte_sel_reg == BYTE_VELOCITY));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = last_trk ? ST_EMIT : ST_READ;
            end
            ST_EMIT:
            begin
                if (track_done && last_trk)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        counter_next   = counter_reg;
        pos_next       = pos_reg;
        trk_next       = trk_reg;
        fire_mask_next = fire_mask_reg;
        note_next      = note_reg;
        byte_sel_next  = byte_sel_reg;
        in_range_next  = in_range_reg;
        hit_valid_next = hit_valid_reg;
        out_valid_next = out_valid_reg && !midi.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    // Advance the loop, or wrap and rewind every track
                    if (counter_reg < loop_period_reg)
                    begin
                        counter_next = counter_reg + 1'b1;
                    end
                    else
                    begin
                        counter_next = '0;
                        for (int i = 0; i < TRACK_COUNT; i++)
                        begin
                            pos_next[i] = '0;
                        end
                    end
                    trk_next       = '0;
                    fire_mask_next = '0;
                end
            end
            ST_READ:
            begin
                in_range_next  = (pos_reg[trk_reg] < POS_W'(STEPS_PER_TRACK));
                hit_valid_next = entry_valid_reg[store_raddr];
            end
            ST_CHECK:
            begin
                if (step_fire)
                begin
                    fire_mask_next[trk_reg] = 1'b1;
                    note_next[trk_reg]      = step_drum;
                    pos_next[trk_reg]       = pos_reg[trk_reg] + 1'b1;
                end
                trk_next      = last_trk ? '0 : trk_reg + 1'b1;
                byte_sel_next = BYTE_STATUS;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    case (byte_sel_reg)
                        BYTE_STATUS:
                        begin
                            out_byte_next = NOTE_ON_STATUS | BYTE_W'(midi_channel_reg);
                            byte_sel_next = BYTE_NOTE;
                        end
                        BYTE_NOTE:
                        begin
                            out_byte_next = BYTE_W'(note_reg[trk_reg]);
                            byte_sel_next = BYTE_VELOCITY;
                        end
                        BYTE_VELOCITY:
                        begin
                            out_byte_next = BYTE_W'(note_velocity_reg);
                            out_last_next = !later_fired;
                            byte_sel_next = BYTE_STATUS;
                        end
                        default:
                        begin
                            byte_sel_next = BYTE_STATUS;
                        end
                    endcase
                end
                if (track_done && !last_trk)
                begin
                    trk_next = trk_reg + 1'b1;
                end
            end
            default:
            begin
                trk_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            trk_reg       <= '0;
            fire_mask_reg <= '0;
            byte_sel_reg  <= BYTE_STATUS;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TRACK_COUNT; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            trk_reg       <= trk_next;
            fire_mask_reg <= fire_mask_next;
            byte_sel_reg  <= byte_sel_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_period_reg   <= PERIOD_RESET;
            midi_channel_reg  <= CHANNEL_RESET;
            note_velocity_reg <= VELOCITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOOP_PERIOD:   loop_period_reg   <= cfg_data[TIME_W-1:0];
                REG_MIDI_CHANNEL:  midi_channel_reg  <= cfg_data[CHAN_W-1:0];
                REG_NOTE_VELOCITY: note_velocity_reg <= cfg_data[VEL_W-1:0];
                default:           loop_period_reg   <= loop_period_reg;
            endcase
        end
    end

    // Store valid flags: a step reads as empty until it is written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else if (store_we)
        begin
            entry_valid_reg[store_waddr] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        note_reg      <= note_next;
        in_range_reg  <= in_range_next;
        hit_valid_reg <= hit_valid_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign midi.valid     = out_valid_reg;
    assign midi.midi_byte = out_byte_reg;
    assign midi.last      = out_last_reg;

    // A track pointer never runs past the end of its track
    for (genvar g = 0; g < TRACK_COUNT; g++)
    begin : g_pos_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            pos_reg[g] <= POS_W'(STEPS_PER_TRACK))
        else $error("track pointer beyond end of track");
    end

    // Only the velocity byte of a message can close a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_last_next) |-> (byte_sel_reg == BYTE_VELOCITY))
    else $error("last flag on a byte other than velocity");

    // A write request leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        write_acc |=> (state_reg == ST_IDLE))
    else $error("write request started a scan");

endmodule

[dv/drum_pattern_sequencer_top_test.sv]
// Self-checking testbench for drum_pattern_sequencer_top: a table of directed
// requests, then random pattern and tick traffic, checked against a predictor.
// Depends on dps_pkg, dps_if and the top-level RTL.
module drum_pattern_sequencer_top_test import dps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HIGH_NS    = 6;
    localparam int CLK_LOW_NS     = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 2 * (1 + 5 * TRACK_COUNT);
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_REQUESTS = 110;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [TRACK_W-1:0] track;
        logic [SLOT_W-1:0] slot;
        logic [NOTE_W-1:0] drum_note;
        logic [TIME_W-1:0] trigger_time;
    } request_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } midi_beat_t;

    // One row of the directed table: either a request or a register write.
    // Where checked is set, the row's bytes are written out by hand.
    typedef struct packed {
        logic                  is_reg;
        request_t              req;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  checked;
        logic [2:0]            n_bytes;
        logic [47:0]           exp_bytes;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dps_cmd_if  cmd ();
    dps_midi_if midi ();

    drum_pattern_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .midi      (midi)
    );

    // Sequencer state as the testbench sees it
    logic [TIME_W-1:0] period_reg;
    logic [CHAN_W-1:0] channel_reg;
    logic [VEL_W-1:0]  velocity_reg;
    logic [TIME_W-1:0] beat_count;
    logic [POS_W-1:0]  play_pos   [TRACK_COUNT];
    logic [NOTE_W-1:0] step_note  [TRACK_COUNT][STEPS_PER_TRACK];
    logic [TIME_W-1:0] step_due   [TRACK_COUNT][STEPS_PER_TRACK];

    logic [BYTE_W-1:0] fired_bytes [$];
    midi_beat_t        pending_bytes [$];
    midi_beat_t        head;

    stim_row_t directed_rows [$];

    int send_idle_pct;
    int take_idle_pct;
    int fail_count;
    int requests_sent;
    int cycle_count;

    // Apply one accepted request to the state and collect the note-on bytes.
    function automatic void advance_sequencer(input request_t req);
        int p;
        fired_bytes.delete();
        if (req.kind == KIND_WRITE)
        begin
            if (req.track < TRACK_COUNT && req.slot < STEPS_PER_TRACK)
            begin
                step_note[req.track][req.slot] = req.drum_note;
                step_due[req.track][req.slot]  = req.trigger_time;
            end
            return;
        end
        if (beat_count < period_reg)
            beat_count = beat_count + 1'b1;
        else
        begin
            beat_count = '0;
            foreach (play_pos[t])
                play_pos[t] = '0;
        end
        for (int t = 0; t < TRACK_COUNT; t++)
        begin
            p = play_pos[t];
            if (p < STEPS_PER_TRACK && step_note[t][p] != '0 && beat_count >= step_due[t][p])
            begin
                fired_bytes.push_back(NOTE_ON_STATUS | {4'b0, channel_reg});
                fired_bytes.push_back({1'b0, step_note[t][p]});
                fired_bytes.push_back({1'b0, velocity_reg});
                play_pos[t] = play_pos[t] + 1'b1;
            end
        end
    endfunction

    function automatic request_t tick_request();
        request_t r;
        r = request_t'($urandom);
        r.kind = KIND_TICK;
        return r;
    endfunction

    function automatic request_t step_request(input int trk, input int slot,
                                              input int note, input int due);
        request_t r;
        r.kind         = KIND_WRITE;
        r.track        = TRACK_W'(trk);
        r.slot         = SLOT_W'(slot);
        r.drum_note    = NOTE_W'(note);
        r.trigger_time = TIME_W'(due);
        return r;
    endfunction

    // Stray request with every field at random
    function automatic request_t noise_request();
        return request_t'($urandom);
    endfunction

    function automatic stim_row_t tick_row(input logic checked, input int n,
                                           input logic [47:0] bytes);
        stim_row_t r;
        r           = '0;
        r.req       = tick_request();
        r.checked   = checked;
        r.n_bytes   = 3'(n);
        r.exp_bytes = bytes;
        return r;
    endfunction

    function automatic stim_row_t write_row(input int trk, input int slot,
                                            input int note, input int due);
        stim_row_t r;
        r         = '0;
        r.req     = step_request(trk, slot, note, due);
        r.checked = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        stim_row_t r;
        r          = '0;
        r.is_reg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = CFG_DATA_W'(data);
        return r;
    endfunction

    // Offer one request, wait for it to be taken and queue its note-on bytes.
    // The valid stays high on return so that a following request can go at once.
    task automatic issue(input request_t req, input logic checked, input int n_typed,
                         input logic [47:0] typed_bytes);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.kind         <= req.kind;
        cmd.track        <= req.track;
        cmd.slot         <= req.slot;
        cmd.drum_note    <= req.drum_note;
        cmd.trigger_time <= req.trigger_time;
        do
            @(posedge clk);
        while (!cmd.ready);
        advance_sequencer(req);
        requests_sent++;
        if (checked)
        begin
            for (int k = 0; k < n_typed; k++)
                pending_bytes.push_back({typed_bytes[47 - 8 * k -: 8], k == n_typed - 1});
        end
        else
        begin
            foreach (fired_bytes[k])
                pending_bytes.push_back({fired_bytes[k], k == fired_bytes.size() - 1});
        end
    endtask

    // Stop offering requests and let the block finish whatever it still holds.
    task automatic wait_until_quiet();
        cmd.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller lowers the write enable after the last one.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_LOOP_PERIOD:   period_reg   = data;
            REG_MIDI_CHANNEL:  channel_reg  = data[CHAN_W-1:0];
            REG_NOTE_VELOCITY: velocity_reg = data[VEL_W-1:0];
            default:           ;
        endcase
    endtask

    // Random traffic: blocks of one register setting, one or two tracks of
    // well-formed steps with non-decreasing trigger times, then enough ticks
    // for a loop or two at the shorter periods, with stray requests mixed in.
    // The ticks stop once the phase has sent its share of requests.
    task automatic run_phase(input int send_pct, input int take_pct);
        int first;
        int period;
        int n_ticks;
        int trk;
        int n_steps;
        int due;
        int sel;
        first         = requests_sent;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        while (requests_sent - first < PHASE_REQUESTS)
        begin
            wait_until_quiet();
            sel = $urandom_range(99);
            if (sel < 5)
                period = 0;
            else if (sel < 10)
                period = (1 << TIME_W) - 1;
            else if (sel < 25)
                period = $urandom_range(1, 8);
            else
                period = $urandom_range(16, 30);
            program_reg(REG_LOOP_PERIOD, CFG_DATA_W'(period));
            program_reg(REG_MIDI_CHANNEL, CFG_DATA_W'($urandom));
            program_reg(REG_NOTE_VELOCITY, CFG_DATA_W'($urandom));
            if ($urandom_range(3) == 0)
                program_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;

            repeat (1 + $urandom_range(1))
            begin
                trk     = $urandom_range(TRACK_COUNT - 1);
                n_steps = ($urandom_range(2) == 0) ? STEPS_PER_TRACK : $urandom_range(3, 12);
                due     = $urandom_range(1);
                for (int k = 0; k < n_steps; k++)
                begin
                    if ($urandom_range(99) < 15)
                        issue(noise_request(), 1'b0, 0, '0);
                    issue(step_request(trk, k,
                                       ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 127),
                                       due), 1'b0, 0, '0);
                    due = due + $urandom_range(2);
                end
            end

            n_ticks = (period > 20) ? 48 : 2 * (period + 1) + 3;
            for (int k = 0; k < n_ticks && requests_sent - first < PHASE_REQUESTS; k++)
            begin
                if ($urandom_range(99) < 10)
                    issue(noise_request(), 1'b0, 0, '0);
                issue(tick_request(), 1'b0, 0, '0);
            end
        end
    endtask

    // Clock
    always
    begin
        clk = 1'b0;
        #CLK_LOW_NS;
        clk = 1'b1;
        #CLK_HIGH_NS;
    end

    // Run-time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Byte sink: random back-pressure and comparison with the oldest expected byte
    always @(posedge clk)
    begin
        midi.ready <= ($urandom_range(99) >= take_idle_pct);
        if (rst_n && midi.valid && midi.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected MIDI byte %0h (last %0b)", midi.midi_byte, midi.last);
                fail_count++;
            end
            else
            begin
                head = pending_bytes.pop_front();
                if (midi.midi_byte !== head.value)
                begin
                    $error("midi_byte: expected %0h, actual %0h", head.value, midi.midi_byte);
                    fail_count++;
                end
                if (midi.last !== head.last)
                begin
                    $error("last: expected %0b, actual %0b", head.last, midi.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        logic      prev_reg;

        // Known levels on every input, reset held
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cmd.valid        = 1'b0;
        cmd.kind         = KIND_TICK;
        cmd.track        = '0;
        cmd.slot         = '0;
        cmd.drum_note    = '0;
        cmd.trigger_time = '0;
        midi.ready       = 1'b0;
        fail_count       = 0;
        requests_sent    = 0;
        cycle_count      = 0;
        send_idle_pct    = 20;
        take_idle_pct    = 64;

        // State after reset: default registers, counter and pointers at zero,
        // every step empty
        period_reg   = PERIOD_RESET;
        channel_reg  = CHANNEL_RESET;
        velocity_reg = VELOCITY_RESET;
        beat_count   = '0;
        foreach (play_pos[t])
            play_pos[t] = '0;
        foreach (step_note[t, s])
        begin
            step_note[t][s] = '0;
            step_due[t][s]  = '0;
        end

        // Directed table. Channel 9 and velocity 60 hold until rewritten.
        // A tick on an empty store is silent.
        directed_rows.push_back(tick_row(1'b1, 0, '0));
        directed_rows.push_back(write_row(0, 0, 127, 0));
        directed_rows.push_back(write_row(1, 0, 1, 2));
        // Drum zero marks an empty step; the latest trigger time never comes.
        directed_rows.push_back(write_row(2, 0, 0, 0));
        directed_rows.push_back(write_row(3, 0, 36, 4095));
        directed_rows.push_back(tick_row(1'b1, 6, 48'h997F3C_99013C));
        directed_rows.push_back(tick_row(1'b1, 0, '0));
        // Lowest channel, highest velocity, and a period of zero so that
        // every tick wraps the counter and rewinds the pointers.
        directed_rows.push_back(reg_row(REG_MIDI_CHANNEL, 0));
        directed_rows.push_back(reg_row(REG_NOTE_VELOCITY, 127));
        directed_rows.push_back(reg_row(REG_LOOP_PERIOD, 0));
        directed_rows.push_back(tick_row(1'b1, 3, 48'h907F7F_000000));
        directed_rows.push_back(tick_row(1'b1, 3, 48'h907F7F_000000));
        // Highest channel, zero velocity, a write to an unmapped index that
        // must change nothing, and the longest period.
        directed_rows.push_back(reg_row(REG_MIDI_CHANNEL, 15));
        directed_rows.push_back(reg_row(REG_NOTE_VELOCITY, 0));
        directed_rows.push_back(reg_row(REG_UNMAPPED, 4095));
        directed_rows.push_back(reg_row(REG_LOOP_PERIOD, 4095));
        directed_rows.push_back(write_row(3, 15, 127, 4095));
        directed_rows.push_back(tick_row(1'b1, 0, '0));
        directed_rows.push_back(tick_row(1'b1, 3, 48'h9F0100_000000));
        // Shortening the period below the counter forces a wrap on the next tick.
        directed_rows.push_back(reg_row(REG_LOOP_PERIOD, 1));
        directed_rows.push_back(tick_row(1'b1, 3, 48'h9F7F00_000000));
        // Three tracks, then all four, firing on one tick.
        directed_rows.push_back(write_row(1, 0, 100, 0));
        directed_rows.push_back(write_row(2, 0, 64, 0));
        directed_rows.push_back(write_row(3, 0, 80, 0));
        directed_rows.push_back(tick_row(1'b0, 0, '0));
        directed_rows.push_back(tick_row(1'b0, 0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; register writes only once the block is idle
        prev_reg = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_reg)
            begin
                if (!prev_reg)
                    wait_until_quiet();
                program_reg(row.reg_idx, row.reg_data);
                if (i + 1 == directed_rows.size() || !directed_rows[i + 1].is_reg)
                    cfg_we <= 1'b0;
            end
            else
                issue(row.req, row.checked, row.n_bytes, row.exp_bytes);
            prev_reg = row.is_reg;
        end

        // Random traffic under three idling patterns
        run_phase(20, 64);
        run_phase(64, 20);
        run_phase(0, 0);

        wait_until_quiet();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/dps_pkg.sv
sv/dps_if.sv
sv/dps_ram.sv
sv/drum_pattern_sequencer_top.sv
dv/drum_pattern_sequencer_top_test.sv
